// ===== rtl/dq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, operation codes and inter-module structs for the deque unit.
// No dependencies; every other file of the deque unit except dq_ram uses this package.

package dq_pkg;

  // Sizing of the element store.
  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed field widths of the channel payloads.
  localparam int OP_W    = 3;
  localparam int DIN_W   = 32;
  localparam int VOUT_W  = 32;
  localparam int COUNT_W = 11;

  // Operation codes carried in the op field.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } op_t;

  // One access of the element store, issued in the accept cycle.
  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [IDX_W-1:0]      addr;
    logic [DATA_WIDTH-1:0] wdata;
  } ram_cmd_t;

  // Status of one operation, carried alongside the store read.
  typedef struct packed {
    logic             rd;
    logic [CNT_W-1:0] count;
    logic             empty;
    logic             ovf;
  } res_info_t;

endpackage

// ===== rtl/dq_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the deque unit: valid/ready handshake with op and data word.
// Depends on dq_pkg for the field widths.

interface dq_in_if;
  logic                     valid;
  logic                     ready;
  logic [dq_pkg::OP_W-1:0]  op;
  logic [dq_pkg::DIN_W-1:0] data_in;

  modport source (output valid, output op, output data_in, input ready);
  modport sink   (input valid, input op, input data_in, output ready);
endinterface

// ===== rtl/dq_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the deque unit: valid/ready handshake with value and status.
// Depends on dq_pkg for the field widths.

interface dq_out_if;
  logic                       valid;
  logic                       ready;
  logic [dq_pkg::VOUT_W-1:0]  value_out;
  logic                       value_valid;
  logic [dq_pkg::COUNT_W-1:0] count_out;
  logic                       is_empty;
  logic                       overflow;

  modport source (output valid, output value_out, output value_valid, output count_out,
                  output is_empty, output overflow, input ready);
  modport sink   (input valid, input value_out, input value_valid, input count_out,
                  input is_empty, input overflow, output ready);
endinterface

// ===== rtl/dq_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; the read data register only changes on a read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dq_ctrl.sv =====
`timescale 1ns / 1ps
// Pointer and count control of the deque: decodes each operation, updates the
// front and back indices and the element count, and issues the store access.
// Depends on dq_pkg.

module dq_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [dq_pkg::OP_W-1:0]         op,
  input  logic [dq_pkg::DIN_W-1:0]        data_in,
  output dq_pkg::ram_cmd_t                cmd,
  output dq_pkg::res_info_t               info
);
  import dq_pkg::*;

  logic [IDX_W-1:0] front_index;
  logic [IDX_W-1:0] front_index_next;
  logic [IDX_W-1:0] back_index;
  logic [IDX_W-1:0] back_index_next;
  logic [CNT_W-1:0] element_count;
  logic [CNT_W-1:0] element_count_next;

  logic             full;
  logic             empty;
  logic [IDX_W-1:0] front_inc;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] back_inc;
  logic [IDX_W-1:0] back_dec;

  // Status of the current contents and the wrapped neighbor indices.
  assign full  = (element_count == CNT_W'(DEPTH));
  assign empty = (element_count == '0);

  assign front_inc = (front_index == IDX_W'(DEPTH - 1)) ? '0 : front_index + 1'b1;
  assign front_dec = (front_index == '0) ? IDX_W'(DEPTH - 1) : front_index - 1'b1;
  assign back_inc  = (back_index == IDX_W'(DEPTH - 1)) ? '0 : back_index + 1'b1;
  assign back_dec  = (back_index == '0) ? IDX_W'(DEPTH - 1) : back_index - 1'b1;

  // Operation decode. Each operation touches at most one entry, so a write and
  // a read never meet in the same cycle and a read in the cycle after a write to
  // the same entry already sees the new value in the array.
  always_comb begin
    front_index_next   = front_index;
    back_index_next    = back_index;
    element_count_next = element_count;
    cmd.we             = 1'b0;
    cmd.re             = 1'b0;
    cmd.addr           = front_index;
    cmd.wdata          = DATA_WIDTH'(data_in);
    info.rd            = 1'b0;
    info.ovf           = 1'b0;
    case (op)
      OP_PUSH_FRONT: begin
        if (full) begin
          info.ovf = 1'b1;
        end else begin
          cmd.we             = 1'b1;
          cmd.addr           = front_dec;
          front_index_next   = front_dec;
          element_count_next = element_count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          info.ovf = 1'b1;
        end else begin
          cmd.we             = 1'b1;
          cmd.addr           = back_index;
          back_index_next    = back_inc;
          element_count_next = element_count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (!empty) begin
          cmd.re             = 1'b1;
          cmd.addr           = front_index;
          info.rd            = 1'b1;
          front_index_next   = front_inc;
          element_count_next = element_count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (!empty) begin
          cmd.re             = 1'b1;
          cmd.addr           = back_dec;
          info.rd            = 1'b1;
          back_index_next    = back_dec;
          element_count_next = element_count - 1'b1;
        end
      end
      OP_PEEK_FRONT: begin
        if (!empty) begin
          cmd.re   = 1'b1;
          cmd.addr = front_index;
          info.rd  = 1'b1;
        end
      end
      OP_PEEK_BACK: begin
        if (!empty) begin
          cmd.re   = 1'b1;
          cmd.addr = back_dec;
          info.rd  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    info.count = element_count_next;
    info.empty = (element_count_next == '0);

    // Nothing happens to the store unless the transaction is accepted.
    if (!accept) begin
      cmd.we = 1'b0;
      cmd.re = 1'b0;
    end
  end

  // Pointer and count registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_index   <= '0;
      back_index    <= '0;
      element_count <= '0;
    end else if (accept) begin
      front_index   <= front_index_next;
      back_index    <= back_index_next;
      element_count <= element_count_next;
    end
  end

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// Bounded double-ended queue of 1024 words of 32 bits held in one RAM, with
// push, pop and peek at either end. Every input transaction yields exactly one
// result transaction, in order. Throughput is one transaction per clock; a
// result passes through the read stage, which holds the registered RAM read,
// and then through the output register. The input stalls only when the output
// register is full and not being taken. A push into a full queue is dropped
// and reported with overflow; a pop or peek on an empty queue returns
// value_valid low and a zero value. The element store needs no clearing
// after reset.
// Depends on dq_pkg, dq_in_if, dq_out_if, dq_ram and dq_ctrl.

module double_ended_queue_unit (
  input logic     clk,
  input logic     rst,
  dq_in_if.sink   in_ch,
  dq_out_if.source out_ch
);
  import dq_pkg::*;

  ram_cmd_t              cmd;
  res_info_t             info;
  logic                  accept;
  logic                  out_load;
  logic [DATA_WIDTH-1:0] rdata;

  logic                  s1_valid;
  res_info_t             s1_info;

  logic                  out_valid;
  logic [VOUT_W-1:0]     out_value;
  logic                  out_value_valid;
  logic [COUNT_W-1:0]    out_count;
  logic                  out_empty;
  logic                  out_ovf;

  // Handshake: the read stage drains whenever the output register has room.
  assign out_load    = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || out_load;
  assign accept      = in_ch.valid && in_ch.ready;

  dq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .op      (in_ch.op),
    .data_in (in_ch.data_in),
    .cmd     (cmd),
    .info    (info)
  );

  // Element store. The read data holds until the next read, which cannot
  // start before the read stage moves on.
  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (cmd.addr),
    .wdata (cmd.wdata),
    .re    (cmd.re),
    .raddr (cmd.addr),
    .rdata (rdata)
  );

  // Read stage: status waits here while the RAM read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= info;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value       <= s1_info.rd ? VOUT_W'(rdata) : '0;
      out_value_valid <= s1_info.rd;
      out_count       <= COUNT_W'(s1_info.count);
      out_empty       <= s1_info.empty;
      out_ovf         <= s1_info.ovf;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.value_out   = out_value;
  assign out_ch.value_valid = out_value_valid;
  assign out_ch.count_out   = out_count;
  assign out_ch.is_empty    = out_empty;
  assign out_ch.overflow    = out_ovf;

endmodule

// ===== rtl/dq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the deque unit's results, bound to the top level.
// Depends on dq_pkg and double_ended_queue_unit.

module dq_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [dq_pkg::VOUT_W-1:0]  value_out,
  input logic                       value_valid,
  input logic [dq_pkg::COUNT_W-1:0] count_out,
  input logic                       is_empty,
  input logic                       overflow
);
  import dq_pkg::*;

  // The empty flag agrees with the reported count.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count_out == '0)))
    else $error("is_empty disagrees with count_out");

  // A result without a found element carries a zero value.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !value_valid) |-> (value_out == '0))
    else $error("value_out nonzero while value_valid is low");

  // A dropped push leaves a full queue and returns no value.
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (count_out == COUNT_W'(DEPTH) && !value_valid))
    else $error("overflow reported while the queue is not full");

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count_out <= COUNT_W'(DEPTH)))
    else $error("count_out exceeds capacity");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(count_out) && $stable(value_out)))
    else $error("stalled result changed");

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .value_out   (out_ch.value_out),
  .value_valid (out_ch.value_valid),
  .count_out   (out_ch.count_out),
  .is_empty    (out_ch.is_empty),
  .overflow    (out_ch.overflow)
);

// ===== dv/tb_double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue_unit: directed corners, a fill to overflow
// under back-pressure, and biased random bursts, all checked against an in-bench deque model.
// Depends on dq_pkg, dq_in_if, dq_out_if and the RTL of the deque unit.

module tb_double_ended_queue_unit;
  import dq_pkg::*;

  // Op codes with no operation behind them; the block still answers them.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam int IDLE_LIMIT      = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int PRINT_LIMIT     = 100;

  typedef struct packed {
    logic [VOUT_W-1:0]  value;
    logic               valid;
    logic [COUNT_W-1:0] count;
    logic               empty;
    logic               overflow;
  } deque_result_t;

  logic clk;
  logic rst;

  dq_in_if  in_ch ();
  dq_out_if out_ch ();

  double_ended_queue_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow deque that tracks every accepted transaction.
  logic [DATA_WIDTH-1:0] deque_store [DEPTH];
  int deque_front = 0;
  int deque_back  = 0;
  int deque_count = 0;

  deque_result_t pending_results [$];
  int error_count     = 0;
  int result_index    = 0;
  int src_idle_pct    = 0;
  int sink_stall_pct  = 0;
  int hold_off_left   = 0;
  bit hold_off_request = 1'b0;
  int quiet_cycles    = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one operation to the shadow deque and return the result it must produce.
  function automatic deque_result_t apply_deque_op(input logic [OP_W-1:0] op,
                                                   input logic [DIN_W-1:0] data);
    deque_result_t r;
    bit full;
    bit empty;
    r = '0;
    full  = (deque_count >= DEPTH);
    empty = (deque_count == 0);
    case (op)
      OP_PUSH_FRONT: begin
        if (full) begin
          r.overflow = 1'b1;
        end else begin
          deque_front = (deque_front == 0) ? DEPTH - 1 : deque_front - 1;
          deque_store[deque_front] = data[DATA_WIDTH-1:0];
          deque_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          r.overflow = 1'b1;
        end else begin
          deque_store[deque_back] = data[DATA_WIDTH-1:0];
          deque_back = (deque_back == DEPTH - 1) ? 0 : deque_back + 1;
          deque_count++;
        end
      end
      OP_POP_FRONT: begin
        if (!empty) begin
          r.value = VOUT_W'(deque_store[deque_front]);
          r.valid = 1'b1;
          deque_front = (deque_front == DEPTH - 1) ? 0 : deque_front + 1;
          deque_count--;
        end
      end
      OP_POP_BACK: begin
        if (!empty) begin
          deque_back = (deque_back == 0) ? DEPTH - 1 : deque_back - 1;
          r.value = VOUT_W'(deque_store[deque_back]);
          r.valid = 1'b1;
          deque_count--;
        end
      end
      OP_PEEK_FRONT: begin
        if (!empty) begin
          r.value = VOUT_W'(deque_store[deque_front]);
          r.valid = 1'b1;
        end
      end
      OP_PEEK_BACK: begin
        if (!empty) begin
          r.value = VOUT_W'(deque_store[(deque_back == 0) ? DEPTH - 1 : deque_back - 1]);
          r.valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(deque_count);
    r.empty = (deque_count == 0);
    return r;
  endfunction

  // Mostly random words, with the all-zero and all-one words mixed in.
  function automatic logic [DIN_W-1:0] random_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return DIN_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    // Keep the log short when the block is badly broken; every failure is still counted.
    if (error_count < PRINT_LIMIT) begin
      $display("ERROR: %s", msg);
    end
    error_count++;
  endtask

  // Offer one transaction, optionally after random idle cycles, and record its result.
  // Valid is left high after acceptance so back-to-back transactions need no toggle.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [DIN_W-1:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.data_in <= data;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(apply_deque_op(op, data));
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // Random bursts that lean toward pushes, toward pops, or neither, so the
  // depth wanders instead of sitting near zero.
  task automatic run_random_ops(input int n_ops);
    int push_pct;
    int burst_left;
    int pick;
    logic [OP_W-1:0] op;
    push_pct   = 50;
    burst_left = 0;
    for (int i = 0; i < n_ops; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 8);
        case ($urandom_range(2))
          0: push_pct = 75;
          1: push_pct = 25;
          default: push_pct = 50;
        endcase
      end
      burst_left--;
      pick = $urandom_range(99);
      if (pick < 4) begin
        op = $urandom_range(1) ? OP_UNUSED_LO : OP_UNUSED_HI;
      end else if (pick < 14) begin
        op = $urandom_range(1) ? OP_PEEK_FRONT : OP_PEEK_BACK;
      end else if ($urandom_range(99) < push_pct) begin
        op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
        op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
      end
      send_op(op, random_word());
    end
  endtask

  // Empty reads, unused codes, extreme words at both ends and order across ends.
  task automatic test_directed_corners();
    set_idling(0, 0);
    send_op(OP_POP_FRONT, '1);
    send_op(OP_POP_BACK, '0);
    send_op(OP_PEEK_FRONT, '1);
    send_op(OP_PEEK_BACK, '0);
    send_op(OP_UNUSED_LO, '1);
    send_op(OP_UNUSED_HI, '0);
    send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_op(OP_PUSH_BACK, 32'h0000_0000);
    send_op(OP_PUSH_FRONT, 32'hA5A5_5A5A);
    send_op(OP_PUSH_BACK, 32'h5A5A_A5A5);
    send_op(OP_PEEK_FRONT, '0);
    send_op(OP_PEEK_BACK, '1);
    send_op(OP_UNUSED_HI, '1);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_PEEK_BACK, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_PEEK_FRONT, '0);
    send_op(OP_PUSH_BACK, 32'h0000_0001);
    send_op(OP_POP_FRONT, '0);
    finish_phase();
  endtask

  // Fill to capacity while the receiver first holds off, push into the full
  // deque, then churn near the top.
  task automatic test_fill_and_overflow();
    set_idling(12, 12);
    hold_off_request = 1'b1;
    while (deque_count < DEPTH) begin
      send_op($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, random_word());
    end
    send_op(OP_PUSH_FRONT, '1);
    send_op(OP_PUSH_BACK, '0);
    send_op(OP_PEEK_FRONT, '0);
    send_op(OP_PEEK_BACK, '0);
    run_random_ops(60);
    finish_phase();
  endtask

  // Random traffic under each idling pattern.
  task automatic test_random_traffic();
    set_idling(0, 0);
    run_random_ops(40);
    finish_phase();
    set_idling(48, 0);
    run_random_ops(40);
    finish_phase();
    set_idling(0, 48);
    run_random_ops(40);
    finish_phase();
    set_idling(12, 12);
    run_random_ops(40);
    finish_phase();
  endtask

  // Result receiver: random stalls, plus one long hold-off counted here.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_off_left--;
      end else if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_off_left    = HOLD_OFF_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    deque_result_t got;
    deque_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{value: out_ch.value_out, valid: out_ch.value_valid, count: out_ch.count_out,
              empty: out_ch.is_empty, overflow: out_ch.overflow};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", result_index));
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value)
          report_mismatch($sformatf("result %0d value_out %0h, expected %0h",
                                    result_index, got.value, want.value));
        if (got.valid !== want.valid)
          report_mismatch($sformatf("result %0d value_valid %0b, expected %0b",
                                    result_index, got.valid, want.valid));
        if (got.count !== want.count)
          report_mismatch($sformatf("result %0d count_out %0d, expected %0d",
                                    result_index, got.count, want.count));
        if (got.empty !== want.empty)
          report_mismatch($sformatf("result %0d is_empty %0b, expected %0b",
                                    result_index, got.empty, want.empty));
        if (got.overflow !== want.overflow)
          report_mismatch($sformatf("result %0d overflow %0b, expected %0b",
                                    result_index, got.overflow, want.overflow));
      end
      result_index++;
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Reset once, run the tests in turn, then judge the run.
  initial begin
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.op      <= OP_PUSH_FRONT;
    in_ch.data_in <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_corners();
    test_random_traffic();
    test_fill_and_overflow();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dq_pkg.sv
rtl/dq_in_if.sv
rtl/dq_out_if.sv
rtl/dq_ram.sv
rtl/dq_ctrl.sv
rtl/double_ended_queue_unit.sv
rtl/dq_checker.sv
dv/tb_double_ended_queue_unit.sv
